>>> sv/ffca_pkg.sv
// shared types, constants and the size rounding function of the first-fit allocator
// used by ffca_ctrl, ffca_dp and the top level; no dependencies
`default_nettype none

package ffca_pkg;

    localparam int unsigned MaxExtentsDefault = 64;

    localparam logic [31:0] WordRoundAdd  = 32'h0000_0003;
    localparam logic [31:0] WordRoundMask = 32'hffff_fffc;
    localparam logic [31:0] PageRoundAdd  = 32'h0000_0fff;
    localparam logic [31:0] PageRoundMask = 32'hffff_f000;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        RD_K   = 2'd0,
        RD_K1  = 2'd1,
        RD_JM1 = 2'd2
    } t_rd_sel;

    typedef enum logic [2:0] {
        WR_NONE   = 3'd0,
        WR_SHRINK = 3'd1,
        WR_DOWN   = 3'd2,
        WR_UP     = 3'd3,
        WR_MPREV  = 3'd4,
        WR_MNEXT  = 3'd5,
        WR_INS    = 3'd6
    } t_wr_sel;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    step_prev;
        logic    inc_k;
        logic    set_j;
        logic    dec_j;
        t_wr_sel wr_sel;
        logic    alloc_ok;
        logic    alloc_miss;
        logic    free_ok;
        logic    remove;
        logic    insert;
        logic    lost;
        logic    clear;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic k_lt_cnt;
        logic j_gt_k;
        logic fits;
        logic exact;
        logic gt_addr;
        logic prev_join;
        logic next_join;
        logic full;
    } t_sts;

    function automatic logic [31:0] round_size(input logic [31:0] sz, input logic page);
        logic [31:0] s;
        s = sz;
        if (page) begin
            s = (s + PageRoundAdd) & PageRoundMask;
        end
        return (s + WordRoundAdd) & WordRoundMask;
    endfunction

endpackage

`default_nettype wire

>>> sv/first_fit_coalescing_allocator.sv
// top level of the first-fit free-list allocator with coalescing
// depends on ffca_pkg, ffca_ctrl and ffca_dp
//
// usage: one request goes in on the slave stream, one result comes out on the
// master stream. requests: allocate, free, clear (opcode 3 does nothing).
// sizes round up to 4 bytes, or to 4 KiB pages when page_granular is set.
// the free list sits in one single-port extent memory kept in address order.
// allocate scans the extents in order and, when an extent empties, shifts the
// later extents down; free scans for the insert point, then shifts extents up
// on insert or down on a double merge. the scans and shifts are bounded by
// MAX_EXTENTS, with the one memory port stepping one entry per read/write pair.
// one request is in flight at a time; tready is high only while idle.
// the result holds on the master side until taken; a stalled receiver holds
// off the next request. reset empties the list and zeroes all statistics,
// with no memory clearing pass.
`default_nettype none

module first_fit_coalescing_allocator #(
    parameter int unsigned MAX_EXTENTS = ffca_pkg::MaxExtentsDefault
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [63:0]  i_s_axis_tdata,  // address[31:0], size[63:32]
    input  wire logic [2:0]   i_s_axis_tuser,  // opcode[1:0], page_granular[2]
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // result_address[31:0], free_entries[38:32], peak_free_entries[45:39],
    // total_free_bytes[77:46], alloc_fail_count[109:78],
    // alloc_fail_bytes[141:110], lost_count[173:142], lost_bytes[205:174]
    output logic [207:0]      o_m_axis_tdata,
    output logic              o_m_axis_tuser   // status[0]
);
    import ffca_pkg::*;

    t_cmd        cmd;
    t_sts        sts;
    logic [31:0] res_addr;
    logic [6:0]  free_ent;
    logic [6:0]  peak_ent;
    logic [31:0] total;
    logic [31:0] fcnt;
    logic [31:0] fbytes;
    logic [31:0] lcnt;
    logic [31:0] lbytes;

    ffca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ffca_dp #(
        .MAX_EXTENTS (MAX_EXTENTS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_opcode            (i_s_axis_tuser[1:0]),
        .i_address           (i_s_axis_tdata[31:0]),
        .i_size              (i_s_axis_tdata[63:32]),
        .i_page_granular     (i_s_axis_tuser[2]),
        .o_result_address    (res_addr),
        .o_status            (o_m_axis_tuser),
        .o_free_entries      (free_ent),
        .o_peak_free_entries (peak_ent),
        .o_total_free_bytes  (total),
        .o_alloc_fail_count  (fcnt),
        .o_alloc_fail_bytes  (fbytes),
        .o_lost_count        (lcnt),
        .o_lost_bytes        (lbytes)
    );

    assign o_m_axis_tdata = {2'b00, lbytes, lcnt, fbytes, fcnt, total,
                             peak_ent, free_ent, res_addr};

endmodule

`default_nettype wire

>>> sv/ffca_dp.sv
// datapath of the allocator: extent memory, scan indexes, counters and statistics
// depends on ffca_pkg; driven by commands from ffca_ctrl
`default_nettype none

module ffca_dp #(
    parameter int unsigned MAX_EXTENTS = ffca_pkg::MaxExtentsDefault
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ffca_pkg::t_cmd i_cmd,
    output ffca_pkg::t_sts     o_sts,
    input  wire logic [1:0]    i_opcode,
    input  wire logic [31:0]   i_address,
    input  wire logic [31:0]   i_size,
    input  wire logic          i_page_granular,
    output logic [31:0]        o_result_address,
    output logic               o_status,
    output logic [6:0]         o_free_entries,
    output logic [6:0]         o_peak_free_entries,
    output logic [31:0]        o_total_free_bytes,
    output logic [31:0]        o_alloc_fail_count,
    output logic [31:0]        o_alloc_fail_bytes,
    output logic [31:0]        o_lost_count,
    output logic [31:0]        o_lost_bytes
);
    import ffca_pkg::*;

    localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);
    localparam int unsigned IW = $clog2(MAX_EXTENTS);

    // each entry holds {length, start}
    logic [63:0] r_mem [MAX_EXTENTS];
    logic [63:0] r_rd;

    t_op         r_op;
    logic [31:0] r_addr;
    logic [31:0] r_sz;
    logic [CW-1:0] r_k;
    logic [CW-1:0] r_j;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_peak;
    logic [31:0] r_prev_start;
    logic [31:0] r_prev_len;
    logic [31:0] r_res;
    logic        r_st;
    logic [31:0] r_total;
    logic [31:0] r_fcnt;
    logic [31:0] r_fbytes;
    logic [31:0] r_lcnt;
    logic [31:0] r_lbytes;

    logic [31:0]   rd_start;
    logic [31:0]   rd_len;
    logic [CW-1:0] k1;
    logic [CW-1:0] km1;
    logic [CW-1:0] jm1;
    logic [CW-1:0] n_count;
    logic [IW-1:0] rd_idx;
    logic [IW-1:0] wr_idx;
    logic [63:0]   wr_data;
    logic [CW+6:0] cnt_ext;
    logic [CW+6:0] peak_ext;

    assign rd_start = r_rd[31:0];
    assign rd_len   = r_rd[63:32];
    assign k1       = r_k + CW'(1);
    assign km1      = r_k - CW'(1);
    assign jm1      = r_j - CW'(1);
    assign n_count  = r_count + CW'(1);

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_K1:   rd_idx = k1[IW-1:0];
            RD_JM1:  rd_idx = jm1[IW-1:0];
            default: rd_idx = r_k[IW-1:0];
        endcase
    end

    always_comb begin
        wr_idx  = r_k[IW-1:0];
        wr_data = r_rd;
        unique case (i_cmd.wr_sel)
            WR_SHRINK: wr_data = {rd_len - r_sz, rd_start + r_sz};
            WR_UP: begin
                wr_idx = r_j[IW-1:0];
            end
            WR_MPREV: begin
                wr_idx  = km1[IW-1:0];
                wr_data = {r_prev_len + r_sz + (o_sts.next_join ? rd_len : 32'd0),
                           r_prev_start};
            end
            WR_MNEXT:  wr_data = {rd_len + r_sz, r_addr};
            WR_INS:    wr_data = {r_sz, r_addr};
            default:   wr_data = r_rd;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_sel != WR_NONE) begin
            r_mem[wr_idx] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[rd_idx];
        end
    end

    // request and scan registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= t_op'(i_opcode);
            r_addr <= i_address;
            r_sz   <= round_size(i_size, i_page_granular);
        end
        if (i_cmd.step_prev) begin
            r_prev_start <= rd_start;
            r_prev_len   <= rd_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k      <= '0;
            r_j      <= '0;
            r_count  <= '0;
            r_peak   <= '0;
            r_res    <= '0;
            r_st     <= 1'b0;
            r_total  <= '0;
            r_fcnt   <= '0;
            r_fbytes <= '0;
            r_lcnt   <= '0;
            r_lbytes <= '0;
        end else begin
            if (i_cmd.load) begin
                r_k   <= '0;
                r_res <= '0;
                r_st  <= 1'b0;
            end
            if (i_cmd.inc_k || i_cmd.step_prev) begin
                r_k <= k1;
            end
            if (i_cmd.set_j) begin
                r_j <= r_count;
            end
            if (i_cmd.dec_j) begin
                r_j <= jm1;
            end
            if (i_cmd.alloc_ok) begin
                r_res   <= rd_start;
                r_total <= r_total - r_sz;
            end
            if (i_cmd.alloc_miss) begin
                r_st     <= 1'b1;
                r_fcnt   <= r_fcnt + 32'd1;
                r_fbytes <= r_fbytes + r_sz;
            end
            if (i_cmd.free_ok || i_cmd.insert) begin
                r_total <= r_total + r_sz;
            end
            if (i_cmd.remove) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.insert) begin
                r_count <= n_count;
                if (r_peak < n_count) begin
                    r_peak <= n_count;
                end
            end
            if (i_cmd.lost) begin
                r_st     <= 1'b1;
                r_lcnt   <= r_lcnt + 32'd1;
                r_lbytes <= r_lbytes + r_sz;
            end
            if (i_cmd.clear) begin
                r_count  <= '0;
                r_peak   <= '0;
                r_total  <= '0;
                r_fcnt   <= '0;
                r_fbytes <= '0;
                r_lcnt   <= '0;
                r_lbytes <= '0;
            end
        end
    end

    always_comb begin
        o_sts.op        = r_op;
        o_sts.k_lt_cnt  = (r_k < r_count);
        o_sts.j_gt_k    = (r_j > r_k);
        o_sts.fits      = (rd_len >= r_sz);
        o_sts.exact     = (rd_len == r_sz);
        o_sts.gt_addr   = (rd_start > r_addr);
        o_sts.prev_join = (r_k != '0) && (r_prev_start + r_prev_len == r_addr);
        o_sts.next_join = (r_k < r_count) && (r_addr + r_sz == rd_start);
        o_sts.full      = (r_count == CW'(MAX_EXTENTS));
    end

    assign cnt_ext             = {7'd0, r_count};
    assign peak_ext            = {7'd0, r_peak};
    assign o_result_address    = r_res;
    assign o_status            = r_st;
    assign o_free_entries      = cnt_ext[6:0];
    assign o_peak_free_entries = peak_ext[6:0];
    assign o_total_free_bytes  = r_total;
    assign o_alloc_fail_count  = r_fcnt;
    assign o_alloc_fail_bytes  = r_fbytes;
    assign o_lost_count        = r_lcnt;
    assign o_lost_bytes        = r_lbytes;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_EXTENTS))
        else $error("extent count beyond capacity");
    a_peak_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak >= r_count)
        else $error("peak below current extent count");
    a_no_insert_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |-> !o_sts.full)
        else $error("insert into a full list");
`endif

endmodule

`default_nettype wire

>>> sv/ffca_ctrl.sv
// controller of the allocator: sequences scan, shift, merge and insert steps
// depends on ffca_pkg; issues commands to ffca_dp
`default_nettype none

module ffca_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    input  wire ffca_pkg::t_sts i_sts,
    output ffca_pkg::t_cmd      o_cmd
);
    import ffca_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_DISP  = 12'b0000_0000_0010,
        S_A_RD  = 12'b0000_0000_0100,
        S_A_EV  = 12'b0000_0000_1000,
        S_DN_RD = 12'b0000_0001_0000,
        S_DN_WR = 12'b0000_0010_0000,
        S_F_RD  = 12'b0000_0100_0000,
        S_F_EV  = 12'b0000_1000_0000,
        S_F_DEC = 12'b0001_0000_0000,
        S_UP_RD = 12'b0010_0000_0000,
        S_UP_WR = 12'b0100_0000_0000,
        S_OUT   = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rd_sel = RD_K;
        o_cmd.wr_sel = WR_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_sts.op)
                    OP_ALLOC: n_state = S_A_RD;
                    OP_FREE:  n_state = S_F_RD;
                    OP_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        n_state = S_OUT;
                    end
                    default:  n_state = S_OUT;
                endcase
            end
            S_A_RD: begin
                if (i_sts.k_lt_cnt) begin
                    o_cmd.rd_en = 1'b1;
                    n_state = S_A_EV;
                end else begin
                    o_cmd.alloc_miss = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_A_EV: begin
                if (i_sts.fits) begin
                    o_cmd.alloc_ok = 1'b1;
                    if (i_sts.exact) begin
                        o_cmd.remove = 1'b1;
                        n_state = S_DN_RD;
                    end else begin
                        o_cmd.wr_sel = WR_SHRINK;
                        n_state = S_OUT;
                    end
                end else begin
                    o_cmd.inc_k = 1'b1;
                    n_state = S_A_RD;
                end
            end
            // close the gap left by a removed extent
            S_DN_RD: begin
                if (i_sts.k_lt_cnt) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_K1;
                    n_state = S_DN_WR;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DN_WR: begin
                o_cmd.wr_sel = WR_DOWN;
                o_cmd.inc_k  = 1'b1;
                n_state = S_DN_RD;
            end
            S_F_RD: begin
                if (i_sts.k_lt_cnt) begin
                    o_cmd.rd_en = 1'b1;
                    n_state = S_F_EV;
                end else begin
                    n_state = S_F_DEC;
                end
            end
            S_F_EV: begin
                if (i_sts.gt_addr) begin
                    n_state = S_F_DEC;
                end else begin
                    o_cmd.step_prev = 1'b1;
                    n_state = S_F_RD;
                end
            end
            S_F_DEC: begin
                priority if (i_sts.prev_join) begin
                    o_cmd.wr_sel  = WR_MPREV;
                    o_cmd.free_ok = 1'b1;
                    if (i_sts.next_join) begin
                        o_cmd.remove = 1'b1;
                        n_state = S_DN_RD;
                    end else begin
                        n_state = S_OUT;
                    end
                end else if (i_sts.next_join) begin
                    o_cmd.wr_sel  = WR_MNEXT;
                    o_cmd.free_ok = 1'b1;
                    n_state = S_OUT;
                end else if (!i_sts.full) begin
                    o_cmd.set_j = 1'b1;
                    n_state = S_UP_RD;
                end else begin
                    o_cmd.lost = 1'b1;
                    n_state = S_OUT;
                end
            end
            // open a slot at the insert point, top entry first
            S_UP_RD: begin
                if (i_sts.j_gt_k) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_JM1;
                    n_state = S_UP_WR;
                end else begin
                    o_cmd.wr_sel = WR_INS;
                    o_cmd.insert = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_UP_WR: begin
                o_cmd.wr_sel = WR_UP;
                o_cmd.dec_j  = 1'b1;
                n_state = S_UP_RD;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output open at once");
    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> o_in_ready && i_in_valid)
        else $error("request loaded outside idle");
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |=> o_in_ready)
        else $error("no return to idle after result transfer");
`endif

endmodule

`default_nettype wire
